// ===== rtl/core/pwook_pkg.sv =====
// Package for the pulse-width OOK frame modulator.
// Holds the frame queue entry type, control/status structs and fixed constants.
// No dependencies.
`default_nettype none

package pwook_pkg;

   // Frame queue geometry
   localparam int QUEUE_DEPTH    = 16;
   localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_FRAME_BITS = 32;

   // Field widths
   localparam int FRAME_W = 32;
   localparam int LEN_W   = 6;
   localparam int IDX_W   = 5;
   localparam int CFG_W   = 16;
   localparam int GAP_W   = 25;

   // Gap multipliers and reset values
   localparam int STARTUP_MULT  = 300;
   localparam int SEQUENCE_MULT = 20;
   localparam logic [CFG_W-1:0] SYMBOL_PERIOD_RESET = 16'd512;
   localparam logic [CFG_W-1:0] FRAME_GAP_RESET     = 16'd1024;
   localparam logic [GAP_W-1:0] GAP_RESET           = 25'd307200;

   typedef enum logic [0:0] {
      CSR_SYMBOL_PERIOD = 1'b0,
      CSR_FRAME_GAP     = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      MODE_TICK    = 1'b0,
      MODE_ENQUEUE = 1'b1
   } mode_type;

   typedef struct packed {
      logic [FRAME_W-1:0] bits;
      logic [LEN_W-1:0]   length;
      logic               ends_sequence;
   } frame_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               full;
      frame_type          head;
   } queue_status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic done;
      logic sending;
   } core_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/pwook_queue.sv =====
// Frame queue of the pulse-width OOK modulator: register storage with head/tail/count.
// Depends on pwook_pkg.
`default_nettype none

module pwook_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pwook_pkg::queue_ctrl_type  ctrl,
   input  wire pwook_pkg::frame_type       push_frame,
   output      pwook_pkg::queue_status_type status
);
   import pwook_pkg::*;

   frame_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] head_ff, head_in;
   logic [QUEUE_AW-1:0] tail_ff, tail_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         tail_in = tail_ff + QUEUE_AW'(1);
      end
      if (ctrl.pop) begin
         head_in = head_ff + QUEUE_AW'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed frame at the tail; entries need no reset
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entry_ff[tail_ff] <= push_frame;
      end
   end

   assign status = '{count: count_ff,
                     full:  (count_ff == COUNT_W'(QUEUE_DEPTH)),
                     head:  entry_ff[head_ff]};

endmodule

`default_nettype wire

// ===== rtl/core/pwook_core.sv =====
// Symbol timing and gap sequencer of the pulse-width OOK modulator.
// Produces one sample per tick transfer and drives queue push/pop. Depends on pwook_pkg.
`default_nettype none

module pwook_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           item_valid,
   input  wire pwook_pkg::mode_type            mode,
   input  wire logic [pwook_pkg::CFG_W-1:0]    symbol_period,
   input  wire logic [pwook_pkg::CFG_W-1:0]    frame_gap,
   input  wire logic                           ifs_write,
   input  wire logic [pwook_pkg::CFG_W-1:0]    ifs_write_value,
   input  wire pwook_pkg::queue_status_type    qstat,
   output      pwook_pkg::queue_ctrl_type      qctrl,
   output      logic                           sample,
   output      logic                           load_accepted,
   output      pwook_pkg::core_status_type     status
);
   import pwook_pkg::*;

   logic               done_ff, done_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic               sending_ff, sending_in;
   logic [LEN_W-1:0]   symidx_ff, symidx_in;
   logic [CFG_W-1:0]   ticks_ff, ticks_in;
   logic [FRAME_W-1:0] bits_ff, bits_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic               ends_ff, ends_in;
   logic               seq_pending_ff, seq_pending_in;

   logic               tick;
   logic [LEN_W-1:0]   cur_idx;
   logic [CFG_W-1:0]   cur_ticks;
   logic [CFG_W+1:0]   three_len;
   logic [CFG_W-1:0]   high_time;
   logic               cur_bit;

   assign tick = item_valid && (mode == MODE_TICK) && !done_ff;

   // Symbol position after a possible rollover
   assign cur_idx   = (ticks_ff == '0) ? symidx_ff + LEN_W'(1) : symidx_ff;
   assign cur_ticks = (ticks_ff == '0) ? symbol_period : ticks_ff;
   assign cur_bit   = bits_ff[cur_idx[IDX_W-1:0]];
   assign three_len = {1'b0, symbol_period, 1'b0} + (CFG_W+2)'(symbol_period);
   assign high_time = cur_bit ? three_len[CFG_W+1:2] : (symbol_period >> 2);

   always_comb begin
      done_in        = done_ff;
      gap_in         = gap_ff;
      sending_in     = sending_ff;
      symidx_in      = symidx_ff;
      ticks_in       = ticks_ff;
      bits_in        = bits_ff;
      length_in      = length_ff;
      ends_in        = ends_ff;
      seq_pending_in = seq_pending_ff;
      // Enqueue when there is room
      qctrl.push     = item_valid && (mode == MODE_ENQUEUE) && !qstat.full;
      qctrl.pop      = 1'b0;
      sample         = 1'b0;

      if (tick) begin
         if (!sending_ff) begin
            // Count down gaps, then insert the sequence gap, finish or load
            if (gap_ff != '0) begin
               gap_in = gap_ff - GAP_W'(1);
            end else if (seq_pending_ff) begin
               seq_pending_in = 1'b0;
               gap_in         = GAP_W'(frame_gap) * GAP_W'(SEQUENCE_MULT);
            end else if (qstat.count == '0) begin
               done_in = 1'b1;
            end else begin
               bits_in    = qstat.head.bits;
               length_in  = qstat.head.length;
               ends_in    = qstat.head.ends_sequence;
               qctrl.pop  = 1'b1;
               symidx_in  = '0;
               ticks_in   = symbol_period;
               sending_in = 1'b1;
            end
         end else begin
            symidx_in = cur_idx;
            ticks_in  = cur_ticks;
            if (cur_idx < length_ff) begin
               // Output high during the first high_time ticks of the symbol
               sample = ((CFG_W+1)'(high_time) + (CFG_W+1)'(cur_ticks))
                        > (CFG_W+1)'(symbol_period);
               if (cur_ticks != '0) begin
                  ticks_in = cur_ticks - CFG_W'(1);
               end
            end else begin
               // End-of-frame tick: start the inter-frame gap
               sending_in = 1'b0;
               gap_in     = GAP_W'(frame_gap);
               if (ends_ff) begin
                  seq_pending_in = 1'b1;
               end
            end
         end
      end

      // Reload the startup gap on a frame gap write
      if (ifs_write) begin
         gap_in = GAP_W'(ifs_write_value) * GAP_W'(STARTUP_MULT);
      end
   end

   assign load_accepted = qctrl.push;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff        <= 1'b0;
         gap_ff         <= GAP_RESET;
         sending_ff     <= 1'b0;
         symidx_ff      <= '0;
         ticks_ff       <= '0;
         bits_ff        <= '0;
         length_ff      <= '0;
         ends_ff        <= 1'b0;
         seq_pending_ff <= 1'b0;
      end else begin
         done_ff        <= done_in;
         gap_ff         <= gap_in;
         sending_ff     <= sending_in;
         symidx_ff      <= symidx_in;
         ticks_ff       <= ticks_in;
         bits_ff        <= bits_in;
         length_ff      <= length_in;
         ends_ff        <= ends_in;
         seq_pending_ff <= seq_pending_in;
      end
   end

   assign status = '{done: done_in, sending: sending_ff};

endmodule

`default_nettype wire

// ===== rtl/core/pulse_width_ook_frame_modulator.sv =====
// Pulse-width on-off-keying frame modulator, top level.
// Usage:
//   req channel: each transfer is one item. tuser selects the kind: 0 is a
//   sample tick, 1 enqueues a frame (tdata bits, length; tlast marks the
//   last frame of a sequence). Frames wait in a 16-entry queue; a full queue
//   rejects the enqueue.
//   rsp channel: exactly one transfer per req transfer, in order, carrying
//   the carrier sample, whether the enqueue was stored, and the sticky
//   finished flag.
//   csr channel: register 0 is the symbol period, register 1 the frame gap;
//   writing the frame gap reloads the startup gap to 300 times the new value.
//   Always ready; write it only while no items are in flight.
// Timing: a req transfer is captured in the input register, then its result in
//   the result register, which drives rsp_tvalid. One item per cycle is
//   sustained while rsp_tready stays high; the update is one single pass.
// Reset: synchronous, active high. Clears the queue, the sequencer and the
//   handshake, and restores a symbol period of 512, a frame gap of 1024 and a
//   startup gap of 307200 ticks.
// Stall: when rsp_tready is low the result holds; the input register still
//   takes one more item, then req_tready drops until the result moves.
`default_nettype none

module pulse_width_ook_frame_modulator (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // req_tdata: frame_bits[31:0], frame_length[37:32], zero pad[39:38]
   input  wire logic                         req_tvalid,
   output      logic                         req_tready,
   input  wire logic [39:0]                  req_tdata,
   input  wire logic                         req_tlast,
   // req_tuser: mode[0]
   input  wire logic                         req_tuser,
   // rsp_tdata: sample[0], load_accepted[1], finished[2], zero pad[7:3]
   output      logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   output      logic [7:0]                   rsp_tdata,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire pwook_pkg::csr_index_type     csr_index,
   input  wire logic [pwook_pkg::CFG_W-1:0]  csr_data
);
   import pwook_pkg::*;

   logic               in_valid_ff;
   mode_type           in_mode_ff;
   frame_type          in_frame_ff;
   frame_type          req_frame;
   logic               out_valid_ff;
   logic               out_sample_ff;
   logic               out_accepted_ff;
   logic               out_finished_ff;
   logic [CFG_W-1:0]   symbol_period_ff;
   logic [CFG_W-1:0]   frame_gap_ff;

   logic               out_free;
   logic               advance;
   logic               req_fire;
   logic               csr_fire;
   logic               ifs_write;
   logic               core_sample;
   logic               core_accepted;
   queue_ctrl_type     qctrl;
   queue_status_type   qstat;
   core_status_type    cstat;

   // Handshake between the two register stages
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign ifs_write  = csr_fire && (csr_index == CSR_FRAME_GAP);

   // Saturate the frame length on capture
   always_comb begin
      req_frame.bits          = req_tdata[FRAME_W-1:0];
      req_frame.length        = req_tdata[FRAME_W+LEN_W-1:FRAME_W];
      req_frame.ends_sequence = req_tlast;
      if (req_frame.length > LEN_W'(MAX_FRAME_BITS)) begin
         req_frame.length = LEN_W'(MAX_FRAME_BITS);
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff  <= mode_type'(req_tuser);
         in_frame_ff <= req_frame;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_period_ff <= SYMBOL_PERIOD_RESET;
         frame_gap_ff     <= FRAME_GAP_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_SYMBOL_PERIOD: symbol_period_ff <= csr_data;
            CSR_FRAME_GAP:     frame_gap_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   pwook_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (qctrl),
      .push_frame (in_frame_ff),
      .status     (qstat)
   );

   pwook_core u_core (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (advance),
      .mode            (in_mode_ff),
      .symbol_period   (symbol_period_ff),
      .frame_gap       (frame_gap_ff),
      .ifs_write       (ifs_write),
      .ifs_write_value (csr_data),
      .qstat           (qstat),
      .qctrl           (qctrl),
      .sample          (core_sample),
      .load_accepted   (core_accepted),
      .status          (cstat)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff   <= core_sample;
         out_accepted_ff <= core_accepted;
         out_finished_ff <= cstat.done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_finished_ff, out_accepted_ff, out_sample_ff};

`ifndef ASSERT_OFF
   // Finished flag is sticky
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      cstat.done |=> cstat.done)
      else $error("finished flag dropped");

   // No frame is in progress once finished
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      !(cstat.done && cstat.sending))
      else $error("sending after finished");

   // A result never carries both a sample and an accepted enqueue
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("sample and load_accepted both set");

   // Queue occupancy stays within depth and never pops when empty
   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      (qstat.count <= COUNT_W'(QUEUE_DEPTH)) && !(qctrl.pop && qstat.count == '0))
      else $error("queue occupancy out of range");
`endif

endmodule

`default_nettype wire

// ===== bench/ook_frame_tracker_pkg.sv =====
// Scoreboard class for the pulse-width OOK frame modulator bench.
// Mirrors the frame queue and symbol sequencer per accepted transfer and checks results.
// Depends on pwook_pkg.
package ook_frame_tracker_pkg;
   import pwook_pkg::*;

   typedef struct packed {
      logic finished;
      logic load_accepted;
      logic sample;
   } ook_result_type;

   class ook_frame_tracker;
      // register copies
      int unsigned symbol_period;
      int unsigned frame_gap;
      // sequencer state
      bit          done_flag;
      int unsigned gap_left;
      bit          sending;
      int unsigned symbol_index;
      int unsigned ticks_left;
      frame_type   active_frame;
      bit          sequence_gap_pending;
      // frame queue
      frame_type   frame_store[QUEUE_DEPTH];
      int unsigned head;
      int unsigned tail;
      int unsigned count;
      ook_result_type expected_results[$];
      int unsigned failures;

      function new();
         symbol_period        = 32'(SYMBOL_PERIOD_RESET);
         frame_gap            = 32'(FRAME_GAP_RESET);
         done_flag            = 1'b0;
         gap_left             = 32'(GAP_RESET);
         sending              = 1'b0;
         symbol_index         = 0;
         ticks_left           = 0;
         active_frame         = '0;
         sequence_gap_pending = 1'b0;
         head                 = 0;
         tail                 = 0;
         count                = 0;
         failures             = 0;
      endfunction

      // Writing the gap length also restarts the startup gap
      function void write_register(csr_index_type index, logic [CFG_W-1:0] value);
         if (index == CSR_SYMBOL_PERIOD) begin
            symbol_period = 32'(value);
         end else begin
            frame_gap = 32'(value);
            gap_left  = STARTUP_MULT * 32'(value);
         end
      endfunction

      // One carrier sample; advances gaps, frame loads and symbols
      function bit advance_tick();
         int unsigned high_ticks;
         bit          level;
         level = 1'b0;
         if (done_flag)
            return 1'b0;
         if (!sending) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (sequence_gap_pending) begin
               // take the long gap after a sequence before the next load
               sequence_gap_pending = 1'b0;
               gap_left = SEQUENCE_MULT * frame_gap;
            end else if (count == 0) begin
               done_flag = 1'b1;
            end else begin
               active_frame = frame_store[head];
               head         = (head + 1) % QUEUE_DEPTH;
               count--;
               symbol_index = 0;
               ticks_left   = symbol_period;
               sending      = 1'b1;
            end
            return 1'b0;
         end
         if (ticks_left == 0) begin
            symbol_index++;
            ticks_left = symbol_period;
         end
         if (symbol_index < active_frame.length) begin
            high_ticks = active_frame.bits[symbol_index] ? (symbol_period * 3) / 4
                                                         : symbol_period / 4;
            level = (high_ticks + ticks_left > symbol_period);
            if (ticks_left > 0)
               ticks_left--;
         end else begin
            // end of frame: quiet sample, start the inter-frame gap
            sending  = 1'b0;
            gap_left = frame_gap;
            if (active_frame.ends_sequence)
               sequence_gap_pending = 1'b1;
         end
         return level;
      endfunction

      // Note an accepted input transfer and queue its expected result
      function void note_item(mode_type mode, logic [FRAME_W-1:0] bits,
                              logic [LEN_W-1:0] length, logic ends);
         ook_result_type result;
         result = '0;
         if (mode == MODE_TICK) begin
            result.sample = advance_tick();
         end else if (count < QUEUE_DEPTH) begin
            frame_store[tail].bits          = bits;
            frame_store[tail].length        = (length > MAX_FRAME_BITS) ?
                                              LEN_W'(MAX_FRAME_BITS) : length;
            frame_store[tail].ends_sequence = ends;
            tail = (tail + 1) % QUEUE_DEPTH;
            count++;
            result.load_accepted = 1'b1;
         end
         result.finished = done_flag;
         expected_results.push_back(result);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      // Check one result transfer against the oldest expectation
      function void check_result(logic [7:0] data);
         ook_result_type want;
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h", data);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("sample", 32'(want.sample), 32'(data[0]));
         compare_field("load_accepted", 32'(want.load_accepted), 32'(data[1]));
         compare_field("finished", 32'(want.finished), 32'(data[2]));
         compare_field("pad", 0, 32'(data[7:3]));
      endfunction
   endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for the pulse-width OOK frame modulator.
// Drives frames and ticks under varied settings and idling; checks each result in order.
// Depends on pwook_pkg, ook_frame_tracker_pkg and the modulator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pwook_pkg::*;
   import ook_frame_tracker_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [39:0]   req_tdata  = '0;
   logic          req_tlast  = 1'b0;
   logic          req_tuser  = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [7:0]    rsp_tdata;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index  = CSR_SYMBOL_PERIOD;
   logic [15:0]   csr_data   = '0;

   ook_frame_tracker tracker;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned enqueue_pct        = 0;
   int unsigned hold_off_cycles    = 0;
   int unsigned cycle_count        = 0;
   bit          draining           = 1'b0;

   pulse_width_ook_frame_modulator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL pulse_width_ook_frame_modulator");
         $finish;
      end
   end

   // Check result transfers; stall at random or hold off for a counted stretch
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata);
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Write both registers once every expected result has come back
   task automatic write_settings(input logic [15:0] symbol_ticks,
                                 input logic [15:0] gap_ticks);
      logic [15:0] value;
      while (tracker.expected_results.size() != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      for (int i = 0; i < 2; i++) begin
         value = (i == 0) ? symbol_ticks : gap_ticks;
         csr_index <= csr_index_type'(i);
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
         tracker.write_register(csr_index_type'(i), value);
      end
      csr_valid <= 1'b0;
   endtask

   // Offer one item after an optional idle gap and hold it until the transfer
   task automatic send_item(input mode_type mode, input logic [31:0] bits,
                            input logic [5:0] length, input logic ends);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, length, bits};
      req_tlast  <= ends;
      do @(posedge clock); while (!req_tready);
      tracker.note_item(mode, bits, length, ends);
   endtask

   // Pick the next item; keep the queue fed so the done flag stays clear until the drain
   task automatic send_chosen_item();
      mode_type    mode;
      logic [31:0] bits;
      logic [5:0]  length;
      logic        ends;
      int unsigned pick;
      bits = $urandom;
      ends = ($urandom_range(99) < 30);
      pick = $urandom_range(99);
      if (pick < 70)
         length = 6'($urandom_range(8, 1));
      else if (pick < 90)
         length = 6'($urandom_range(32, 9));
      else if (pick < 93)
         length = '0;
      else
         length = 6'($urandom_range(63, 33));
      if (draining)
         mode = (tracker.done_flag && $urandom_range(1)) ? MODE_ENQUEUE : MODE_TICK;
      else if (tracker.count == 0 || $urandom_range(99) < enqueue_pct)
         mode = MODE_ENQUEUE;
      else
         mode = MODE_TICK;
      send_item(mode, bits, length, ends);
   endtask

   task automatic run_phase(input logic [15:0] symbol_ticks, input logic [15:0] gap_ticks,
                            input int unsigned items, input int unsigned enq_pct,
                            input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned hold);
      write_settings(symbol_ticks, gap_ticks);
      enqueue_pct        = enq_pct;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      hold_off_cycles    = hold;
      repeat (items)
         send_chosen_item();
      req_tvalid <= 1'b0;
   endtask

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero and oversized lengths, extreme bit patterns, sequence ends
      write_settings(16'd4, 16'd0);
      send_item(MODE_ENQUEUE, 32'h0000_0000, 6'd0, 1'b0);
      send_item(MODE_ENQUEUE, 32'hFFFF_FFFF, 6'd63, 1'b1);
      send_item(MODE_ENQUEUE, 32'h0000_0000, 6'd1, 1'b0);
      send_item(MODE_ENQUEUE, 32'hA5A5_5A5A, 6'd32, 1'b1);
      repeat (21)
         send_item(MODE_TICK, $urandom, 6'($urandom_range(63)), 1'($urandom_range(1)));
      req_tvalid <= 1'b0;

      // Random phases across settings, extremes among them
      run_phase(16'd4,     16'd3,     150, 15, 0,  0,  300);
      run_phase(16'd0,     16'd2,     150, 20, 82, 0,  0);
      run_phase(16'd7,     16'd1,     150, 30, 0,  82, 0);
      // Let the running frame end so the longest symbol never starts
      while (tracker.sending)
         send_item(MODE_TICK, 32'h0000_0000, 6'd0, 1'b0);
      req_tvalid <= 1'b0;
      run_phase(16'd65535, 16'd65535, 60,  50, 34, 34, 0);
      run_phase(16'd1,     16'd0,     100, 10, 0,  0,  0);
      run_phase(16'd3,     16'd4,     150, 25, 0,  82, 0);
      run_phase(16'd12,    16'd2,     150, 20, 34, 34, 0);
      run_phase(16'd2,     16'd1,     100, 15, 82, 0,  0);

      // Drain the queue until finished, then items after the flag is set
      write_settings(16'd0, 16'd0);
      sender_idle_pct    = 34;
      receiver_stall_pct = 34;
      draining           = 1'b1;
      while (!tracker.done_flag)
         send_chosen_item();
      repeat (24)
         send_chosen_item();
      req_tvalid <= 1'b0;

      while (tracker.expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.failures == 0)
         $display("PASS pulse_width_ook_frame_modulator");
      else
         $display("FAIL pulse_width_ook_frame_modulator");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pwook_pkg.sv
rtl/core/pwook_queue.sv
rtl/core/pwook_core.sv
rtl/core/pulse_width_ook_frame_modulator.sv
bench/ook_frame_tracker_pkg.sv
bench/tb_top.sv
